// File: design/cfpr_pkg.sv
`timescale 1ns / 1ps

package cfpr_pkg;

  localparam int unsigned MaxLenWidth = 9;
  localparam int unsigned CountWidth = 9;
  localparam int unsigned CrcWidth = 16;
  localparam int unsigned ClassWidth = 3;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned RecentDepth = 6;

  localparam logic [MaxLenWidth-1:0] MAX_LEN_RESET = 9'd260;
  localparam logic [CountWidth-1:0] MAX_TOTAL_LEN = 9'd260;
  localparam logic [CrcWidth-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CrcWidth-1:0] CRC_POLY = 16'h8408;
  localparam logic [7:0] START_BYTE = 8'h78;

  localparam logic [StatusWidth-1:0] ST_GOOD = 2'd0;
  localparam logic [StatusWidth-1:0] ST_BAD_CRC = 2'd1;
  localparam logic [StatusWidth-1:0] ST_BAD_LEN = 2'd2;
  localparam logic [StatusWidth-1:0] ST_BAD_HDR = 2'd3;

  localparam logic [ClassWidth-1:0] CLS_LOGIN = 3'd0;
  localparam logic [ClassWidth-1:0] CLS_POSITION = 3'd1;
  localparam logic [ClassWidth-1:0] CLS_STATUS = 3'd2;
  localparam logic [ClassWidth-1:0] CLS_CMD_REPLY = 3'd3;
  localparam logic [ClassWidth-1:0] CLS_COMMAND = 3'd4;
  localparam logic [ClassWidth-1:0] CLS_PHOTO = 3'd5;

  localparam logic [7:0] PROTO_LOGIN = 8'h01;
  localparam logic [7:0] PROTO_POSITION = 8'h12;
  localparam logic [7:0] PROTO_STATUS = 8'h13;
  localparam logic [7:0] PROTO_CMD_REPLY = 8'h15;
  localparam logic [7:0] PROTO_COMMAND = 8'h80;
  localparam logic [7:0] PROTO_PHOTO = 8'h20;

  localparam logic [1:0] REG_MAX_FRAME_LEN = 2'd0;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [ClassWidth-1:0]  message_class;
    logic [7:0]             protocol_byte;
    logic [7:0]             length_byte;
    logic [15:0]            serial_number;
  } result_t;

  typedef struct packed {
    logic       known;
    logic [ClassWidth-1:0] cls;
  } class_lookup_t;

  function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc_in,
                                                   input logic [7:0] data);
    logic [CrcWidth-1:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  function automatic class_lookup_t proto_class(input logic [7:0] proto);
    class_lookup_t r;
    r.known = 1'b1;
    r.cls = CLS_LOGIN;
    case (proto)
      PROTO_LOGIN:     r.cls = CLS_LOGIN;
      PROTO_POSITION:  r.cls = CLS_POSITION;
      PROTO_STATUS:    r.cls = CLS_STATUS;
      PROTO_CMD_REPLY: r.cls = CLS_CMD_REPLY;
      PROTO_COMMAND:   r.cls = CLS_COMMAND;
      PROTO_PHOTO:     r.cls = CLS_PHOTO;
      default:         r.known = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] class_proto(input logic [ClassWidth-1:0] cls);
    logic [7:0] p;
    case (cls)
      CLS_LOGIN:     p = PROTO_LOGIN;
      CLS_POSITION:  p = PROTO_POSITION;
      CLS_STATUS:    p = PROTO_STATUS;
      CLS_CMD_REPLY: p = PROTO_CMD_REPLY;
      CLS_COMMAND:   p = PROTO_COMMAND;
      CLS_PHOTO:     p = PROTO_PHOTO;
      default:       p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// File: design/cfpr_regs.sv
`timescale 1ns / 1ps

module cfpr_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [cfpr_pkg::MaxLenWidth-1:0]    max_frame_len
);
  import cfpr_pkg::*;

  logic sel_max;

  assign pready = 1'b1;
  assign sel_max = (paddr[2] == REG_MAX_FRAME_LEN[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && sel_max) begin
      max_frame_len <= pwdata[MaxLenWidth-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (sel_max) begin
      prdata = {{(32-MaxLenWidth){1'b0}}, max_frame_len};
    end
  end

endmodule

// File: design/cfpr_in_reg.sv
`timescale 1ns / 1ps

module cfpr_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic load;

  assign load = in_valid && (!held_valid || take);
  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!held_valid || take) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// File: design/cfpr_parser.sv
`timescale 1ns / 1ps

module cfpr_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              held_valid,
  input  logic [7:0]                        held_byte,
  input  logic [cfpr_pkg::MaxLenWidth-1:0]  max_frame_len,
  output logic                              take,
  output logic                              res_valid,
  input  logic                              res_stall,
  output cfpr_pkg::result_t                 res
);
  import cfpr_pkg::*;

  logic [CountWidth-1:0] byte_count, byte_count_next;
  logic [CountWidth-1:0] frame_length, frame_length_next;
  logic [CrcWidth-1:0]   running_crc, running_crc_next;
  logic                  crc_active, crc_active_next;
  logic [ClassWidth-1:0] class_reg, class_reg_next;
  logic [7:0]            recent_bytes [RecentDepth];
  logic [7:0]            recent_next [RecentDepth];
  logic [CountWidth-1:0] cnt;
  logic                  emit;
  result_t               res_next;
  class_lookup_t         lookup;
  logic [15:0]           crc_field;

  assign take = held_valid && (!res_valid || !res_stall);
  assign cnt = byte_count + 9'd1;
  assign lookup = proto_class(held_byte);

  always_comb begin
    recent_next[0] = held_byte;
    for (int k = 1; k < RecentDepth; k++) begin
      recent_next[k] = recent_bytes[k-1];
    end
  end

  assign crc_field = {recent_next[3], recent_next[2]};

  always_comb begin
    byte_count_next = byte_count;
    frame_length_next = frame_length;
    running_crc_next = running_crc;
    crc_active_next = crc_active;
    class_reg_next = class_reg;
    emit = 1'b0;
    res_next.status = ST_GOOD;
    res_next.message_class = class_reg;
    res_next.protocol_byte = class_proto(class_reg);
    res_next.length_byte = 8'd0;
    res_next.serial_number = 16'd0;

    if (byte_count == '0) begin
      if (held_byte == START_BYTE) begin
        byte_count_next = 9'd1;
        frame_length_next = '0;
        running_crc_next = CRC_INIT;
        crc_active_next = 1'b1;
        class_reg_next = CLS_LOGIN;
      end
    end else begin
      byte_count_next = cnt;
      if (byte_count == 9'd2) begin
        frame_length_next = {1'b0, held_byte} + 9'd5;
      end
      if (byte_count >= 9'd2 && crc_active) begin
        running_crc_next = crc_byte(running_crc, held_byte);
        if ({1'b0, byte_count} + 10'd5 == {1'b0, frame_length_next}) begin
          crc_active_next = 1'b0;
        end
      end
      res_next.length_byte = frame_length_next[7:0] - 8'd5;

      if (cnt == 9'd4) begin
        if (recent_next[2] != START_BYTE || !lookup.known) begin
          emit = 1'b1;
          res_next.status = ST_BAD_HDR;
          res_next.message_class = CLS_LOGIN;
          res_next.protocol_byte = held_byte;
          res_next.length_byte = recent_next[1];
          byte_count_next = '0;
        end else begin
          class_reg_next = lookup.cls;
        end
      end else if (cnt == 9'd7) begin
        if (frame_length <= 9'd7 || frame_length > max_frame_len) begin
          emit = 1'b1;
          res_next.status = ST_BAD_LEN;
          byte_count_next = '0;
        end
      end else if (cnt > 9'd7 && cnt == frame_length) begin
        emit = 1'b1;
        res_next.status = (running_crc == ~crc_field) ? ST_GOOD : ST_BAD_CRC;
        res_next.serial_number = {recent_next[5], recent_next[4]};
        byte_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      frame_length <= '0;
      running_crc <= CRC_INIT;
      crc_active <= 1'b1;
      class_reg <= CLS_LOGIN;
      for (int k = 0; k < RecentDepth; k++) begin
        recent_bytes[k] <= 8'd0;
      end
    end else if (take) begin
      byte_count <= byte_count_next;
      frame_length <= frame_length_next;
      running_crc <= running_crc_next;
      crc_active <= crc_active_next;
      class_reg <= class_reg_next;
      for (int k = 0; k < RecentDepth; k++) begin
        recent_bytes[k] <= recent_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= emit;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_next;
    end
  end

  // Once the length has passed its check, the count stays within the frame.
  assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_TOTAL_LEN)
    else $error("byte count beyond the longest frame");

  assert property (@(posedge clk) disable iff (rst)
    byte_count >= 9'd7 |-> (frame_length >= 9'd8 && frame_length <= MAX_TOTAL_LEN))
    else $error("frame length out of range past the length check");

  assert property (@(posedge clk) disable iff (rst)
    (byte_count >= 9'd7 && {1'b0, byte_count} + 10'd5 > {1'b0, frame_length})
      |-> !crc_active)
    else $error("checksum still running over the checksum field");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == ST_BAD_HDR || res.status == ST_BAD_LEN))
      |-> res.serial_number == 16'd0)
    else $error("rejected frame reports a serial number");

  assert property (@(posedge clk) disable iff (rst)
    (take && emit) |=> (res_valid && byte_count == '0))
    else $error("result issued without returning to hunting");

endmodule

// File: design/crc16_framed_packet_receiver_unit.sv
`timescale 1ns / 1ps
// Result path: the byte that completes or rejects a frame passes the input register, then the
// parser writes its result word into the result register. Throughput: one byte per cycle when
// no result is stalled; a stalled result holds one further byte in the input register.
// Reset (rst, synchronous): the receiver returns to hunting, the checksum restarts at all ones,
// no result is pending and max_frame_len returns to 260.
module crc16_framed_packet_receiver_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [cfpr_pkg::StatusWidth-1:0]      status,
  output logic [cfpr_pkg::ClassWidth-1:0]       message_class,
  output logic [7:0]                            protocol_byte,
  output logic [7:0]                            length_byte,
  output logic [15:0]                           serial_number,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import cfpr_pkg::*;

  logic [MaxLenWidth-1:0] max_frame_len;
  logic                   take;
  logic                   held_valid;
  logic [7:0]             held_byte;
  result_t                res;

  cfpr_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_frame_len (max_frame_len)
  );

  cfpr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  cfpr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .held_valid    (held_valid),
    .held_byte     (held_byte),
    .max_frame_len (max_frame_len),
    .take          (take),
    .res_valid     (out_valid),
    .res_stall     (out_stall),
    .res           (res)
  );

  assign status = res.status;
  assign message_class = res.message_class;
  assign protocol_byte = res.protocol_byte;
  assign length_byte = res.length_byte;
  assign serial_number = res.serial_number;

endmodule
